>>> sv/sbsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsh_pkg
// Shared types, round constants and sigma functions for the byte-stream
// SHA-256 hasher.
// ----------------------------------------------------------------------------
package sbsh_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0]  byte_t;

	localparam int unsigned BlockWords = 16;
	localparam int unsigned ChainWords = 8;
	localparam int unsigned Rounds     = 64;
	localparam int unsigned CountBits  = 61;

	localparam logic [5:0] LenOffset = 6'd56;
	localparam logic [5:0] LastByte  = 6'd63;
	localparam logic [5:0] LastRound = 6'd63;
	localparam byte_t      PadMark   = 8'h80;

	localparam logic op_absorb = 1'b0;
	localparam logic op_finish = 1'b1;

	function automatic word_t rotr32(input word_t x, input int unsigned n);
		rotr32 = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t init_hash(input logic [2:0] idx);
		case (idx)
			3'd0: init_hash = 32'h6A09E667;
			3'd1: init_hash = 32'hBB67AE85;
			3'd2: init_hash = 32'h3C6EF372;
			3'd3: init_hash = 32'hA54FF53A;
			3'd4: init_hash = 32'h510E527F;
			3'd5: init_hash = 32'h9B05688C;
			3'd6: init_hash = 32'h1F83D9AB;
			default: init_hash = 32'h5BE0CD19;
		endcase
	endfunction

	function automatic word_t round_k(input logic [5:0] idx);
		case (idx)
			6'd0:  round_k = 32'h428A2F98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hB5C0FBCF;
			6'd3:  round_k = 32'hE9B5DBA5;
			6'd4:  round_k = 32'h3956C25B;
			6'd5:  round_k = 32'h59F111F1;
			6'd6:  round_k = 32'h923F82A4;
			6'd7:  round_k = 32'hAB1C5ED5;
			6'd8:  round_k = 32'hD807AA98;
			6'd9:  round_k = 32'h12835B01;
			6'd10: round_k = 32'h243185BE;
			6'd11: round_k = 32'h550C7DC3;
			6'd12: round_k = 32'h72BE5D74;
			6'd13: round_k = 32'h80DEB1FE;
			6'd14: round_k = 32'h9BDC06A7;
			6'd15: round_k = 32'hC19BF174;
			6'd16: round_k = 32'hE49B69C1;
			6'd17: round_k = 32'hEFBE4786;
			6'd18: round_k = 32'h0FC19DC6;
			6'd19: round_k = 32'h240CA1CC;
			6'd20: round_k = 32'h2DE92C6F;
			6'd21: round_k = 32'h4A7484AA;
			6'd22: round_k = 32'h5CB0A9DC;
			6'd23: round_k = 32'h76F988DA;
			6'd24: round_k = 32'h983E5152;
			6'd25: round_k = 32'hA831C66D;
			6'd26: round_k = 32'hB00327C8;
			6'd27: round_k = 32'hBF597FC7;
			6'd28: round_k = 32'hC6E00BF3;
			6'd29: round_k = 32'hD5A79147;
			6'd30: round_k = 32'h06CA6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27B70A85;
			6'd33: round_k = 32'h2E1B2138;
			6'd34: round_k = 32'h4D2C6DFC;
			6'd35: round_k = 32'h53380D13;
			6'd36: round_k = 32'h650A7354;
			6'd37: round_k = 32'h766A0ABB;
			6'd38: round_k = 32'h81C2C92E;
			6'd39: round_k = 32'h92722C85;
			6'd40: round_k = 32'hA2BFE8A1;
			6'd41: round_k = 32'hA81A664B;
			6'd42: round_k = 32'hC24B8B70;
			6'd43: round_k = 32'hC76C51A3;
			6'd44: round_k = 32'hD192E819;
			6'd45: round_k = 32'hD6990624;
			6'd46: round_k = 32'hF40E3585;
			6'd47: round_k = 32'h106AA070;
			6'd48: round_k = 32'h19A4C116;
			6'd49: round_k = 32'h1E376C08;
			6'd50: round_k = 32'h2748774C;
			6'd51: round_k = 32'h34B0BCB5;
			6'd52: round_k = 32'h391C0CB3;
			6'd53: round_k = 32'h4ED8AA4A;
			6'd54: round_k = 32'h5B9CCA4F;
			6'd55: round_k = 32'h682E6FF3;
			6'd56: round_k = 32'h748F82EE;
			6'd57: round_k = 32'h78A5636F;
			6'd58: round_k = 32'h84C87814;
			6'd59: round_k = 32'h8CC70208;
			6'd60: round_k = 32'h90BEFFFA;
			6'd61: round_k = 32'hA4506CEB;
			6'd62: round_k = 32'hBEF9A3F7;
			default: round_k = 32'hC67178F2;
		endcase
	endfunction

endpackage

>>> sv/sha256_byte_stream_hasher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// SHA-256 over a byte stream: absorb bytes one at a time, finish to pad the
// message and emit the 256-bit digest as eight words.
// ----------------------------------------------------------------------------
// An absorb item writes its byte into the block buffer. The item that
// completes a 64-byte block is followed by the 64 rounds and the chaining
// add, during which in_ready is low; the single round unit does one SHA-256
// round and one schedule word per cycle. A finish item writes the padding
// one byte a cycle from the current fill up to the block end, runs one
// compression (two when the fill is 56 or more), and then loads the digest
// into the output register; in_ready returns once the digest is loaded.
// Absorb items are still taken while a digest waits for out_ready; a later
// finish holds until that digest has been taken.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word0,
	output logic [31:0] digest_word1,
	output logic [31:0] digest_word2,
	output logic [31:0] digest_word3,
	output logic [31:0] digest_word4,
	output logic [31:0] digest_word5,
	output logic [31:0] digest_word6,
	output logic [31:0] digest_word7
);
	import sbsh_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ROUND,
		S_FOLD,
		S_EMIT
	} state_t;

	state_t                 state_q;
	logic [5:0]             fill_q;
	logic [CountBits-1:0]   count_q;
	logic [5:0]             round_q;
	logic                   mark_q;
	logic                   len_blk_q;
	logic                   fin_q;
	logic                   out_valid_q;
	word_t                  chain_q  [ChainWords];
	word_t                  v_q      [ChainWords];
	word_t                  w_q      [BlockWords];
	word_t                  digest_q [ChainWords];

	logic       in_acc;
	logic       absorb_acc;
	logic       finish_acc;
	logic       wr_en;
	byte_t      wr_byte;
	byte_t      pad_byte;
	byte_t      len_byte;
	logic [63:0] bit_len;
	logic [2:0] len_sel;
	logic [3:0] wr_word;
	logic [4:0] wr_pos;
	logic       blk_full;
	logic       emit_go;

	word_t t1, t2, new_w;

	assign in_ready   = (state_q == S_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign absorb_acc = in_acc && (op == op_absorb);
	assign finish_acc = in_acc && (op == op_finish);
	assign out_valid  = out_valid_q;
	assign emit_go    = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// padding byte: marker first, zeros, then the big-endian bit length
	assign bit_len  = {count_q, 3'b000};
	assign len_sel  = 3'd7 - fill_q[2:0];
	assign len_byte = bit_len[{len_sel, 3'b000} +: 8];

	always_comb begin
		if (mark_q) begin
			pad_byte = PadMark;
		end else if (len_blk_q && (fill_q >= LenOffset)) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign wr_en    = absorb_acc || (state_q == S_PAD);
	assign wr_byte  = (state_q == S_PAD) ? pad_byte : data_byte;
	assign wr_word  = fill_q[5:2];
	assign wr_pos   = {~fill_q[1:0], 3'b000};
	assign blk_full = wr_en && (fill_q == LastByte);

	// shared round unit and schedule expansion
	always_comb begin
		t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_k(round_q) + w_q[0];
		t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		new_w = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			count_q     <= '0;
			round_q     <= '0;
			mark_q      <= 1'b0;
			len_blk_q   <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ChainWords; i++) begin
				chain_q[i] <= init_hash(3'(i));
			end
		end else begin
			if (out_valid_q && out_ready && !emit_go) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				fill_q <= fill_q + 6'd1;
				mark_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (absorb_acc) begin
						count_q <= count_q + CountBits'(1);
						fin_q   <= 1'b0;
						if (blk_full) begin
							round_q <= '0;
							state_q <= S_ROUND;
						end
					end else if (finish_acc) begin
						fin_q     <= 1'b1;
						mark_q    <= 1'b1;
						len_blk_q <= (fill_q < LenOffset);
						state_q   <= S_PAD;
					end
				end
				S_PAD: begin
					if (blk_full) begin
						round_q <= '0;
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == LastRound) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					for (int i = 0; i < ChainWords; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					if (!fin_q) begin
						state_q <= S_IDLE;
					end else if (len_blk_q) begin
						state_q <= S_EMIT;
					end else begin
						// marker spilled past the length field: one more block
						len_blk_q <= 1'b1;
						state_q   <= S_PAD;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						count_q     <= '0;
						fill_q      <= '0;
						fin_q       <= 1'b0;
						len_blk_q   <= 1'b0;
						state_q     <= S_IDLE;
						for (int i = 0; i < ChainWords; i++) begin
							chain_q[i] <= init_hash(3'(i));
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// block words, working variables and digest register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			w_q[wr_word][wr_pos +: 8] <= wr_byte;
		end else if (state_q == S_ROUND) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BlockWords - 1] <= new_w;
		end
		if (blk_full) begin
			for (int i = 0; i < ChainWords; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (state_q == S_ROUND) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
		if (emit_go) begin
			for (int i = 0; i < ChainWords; i++) begin
				digest_q[i] <= chain_q[i];
			end
		end
	end

	assign digest_word0 = digest_q[0];
	assign digest_word1 = digest_q[1];
	assign digest_word2 = digest_q[2];
	assign digest_word3 = digest_q[3];
	assign digest_word4 = digest_q[4];
	assign digest_word5 = digest_q[5];
	assign digest_word6 = digest_q[6];
	assign digest_word7 = digest_q[7];

	// a finish item always goes to padding next
	assert property (@(posedge clk) disable iff (!arst_n)
		finish_acc |=> (state_q == S_PAD))
		else $error("finish item did not start padding");

	// compression always starts at round zero on an empty buffer count
	assert property (@(posedge clk) disable iff (!arst_n)
		blk_full |=> (state_q == S_ROUND) && (round_q == 6'd0) && (fill_q == 6'd0))
		else $error("compression started with bad round or fill");

	// a digest is presented only after the emit step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
		else $error("digest valid without emit");

	// a pending digest is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(digest_q[0]))
		else $error("pending digest lost");

	// emit restores the initial chaining state and clears the length
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (chain_q[0] == init_hash(3'd0)) && (count_q == '0) && (fill_q == '0))
		else $error("state not restarted after digest");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte-stream SHA-256 hasher check. Messages of chosen and random lengths are
// fed one byte per item, each closed by a finish item. The expected digests
// come from an independent SHA-256 predictor and are compared word by word
// with every digest that the block emits. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
	import sbsh_pkg::*;

	typedef logic [0:7][31:0] digest_t;

	// sha-256 predictor with its own chaining state and a queue of digests owed
	class digest_tracker;
		word_t     round_const [64];
		word_t     start_words [8];
		word_t     chain [8];
		byte_t     blk [64];
		int        fill;
		logic [60:0] msg_len;
		digest_t   pending_digests [$];
		int        errors;

		function new();
			round_const = '{
				32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
				32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
				32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
				32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
				32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
				32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
				32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
				32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
				32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
				32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
				32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
				32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
				32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
				32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
				32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
				32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
			start_words = '{
				32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
				32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
			errors = 0;
			restart();
		endfunction

		function void restart();
			chain = start_words;
			fill = 0;
			msg_len = '0;
		endfunction

		function word_t ror(word_t x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			word_t w [64];
			word_t v [8];
			word_t s0, s1, t1, t2;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (int i = 16; i < 64; i++) begin
				s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + s0 + w[i-7] + s1;
			end
			v = chain;
			for (int i = 0; i < 64; i++) begin
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const[i] + w[i];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				chain[i] = chain[i] + v[i];
		endfunction

		function void note_item(logic op_in, byte_t b);
			logic [63:0] bit_len;
			digest_t d;
			if (op_in == op_absorb) begin
				blk[fill] = b;
				fill++;
				msg_len++;
				if (fill == 64) begin
					compress();
					fill = 0;
				end
			end else begin
				bit_len = {msg_len, 3'b000};
				blk[fill] = PadMark;
				fill++;
				// no room left for the length field: pad out and take one more block
				if (fill > int'(LenOffset)) begin
					for (int i = fill; i < 64; i++)
						blk[i] = 8'h00;
					compress();
					fill = 0;
				end
				for (int i = fill; i < int'(LenOffset); i++)
					blk[i] = 8'h00;
				for (int i = 0; i < 8; i++)
					blk[63-i] = bit_len[8*i +: 8];
				compress();
				for (int i = 0; i < 8; i++)
					d[i] = chain[i];
				pending_digests = {pending_digests, d};
				restart();
			end
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_digest(digest_t got);
			digest_t want;
			if (pending_digests.size() == 0) begin
				report($sformatf("digest %h with none expected", got));
			end else begin
				want = pending_digests.pop_front();
				for (int i = 0; i < 8; i++)
					if (got[i] !== want[i])
						report($sformatf("digest_word%0d got %h want %h", i, got[i], want[i]));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	digest_t     digest;

	digest_tracker tracker;
	int          items_sent;
	int          send_burst;
	int          recv_burst;

	sha256_byte_stream_hasher_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digest_word0 (digest[0]),
		.digest_word1 (digest[1]),
		.digest_word2 (digest[2]),
		.digest_word3 (digest[3]),
		.digest_word4 (digest[4]),
		.digest_word5 (digest[5]),
		.digest_word6 (digest[6]),
		.digest_word7 (digest[7])
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle length per item, with occasional stretches of no idling at all
	function automatic int draw_wait(inout int burst);
		if (burst == 0 && $urandom_range(0, 15) == 0)
			burst = $urandom_range(10, 40);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	task send_item(logic op_in, byte_t b);
		int gap;
		gap = draw_wait(send_burst);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		op        = op_in;
		data_byte = b;
		do @(posedge clk); while (!in_ready);
		tracker.note_item(op_in, b);
		items_sent++;
	endtask

	task send_message(int len);
		for (int i = 0; i < len; i++)
			send_item(op_absorb, byte_t'($urandom_range(0, 255)));
		send_item(op_finish, byte_t'($urandom_range(0, 255)));
	endtask

	function automatic int pick_length();
		int r;
		int edges [10] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120};
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom_range(0, 16);
		else if (r < 7)
			return edges[$urandom_range(0, 9)];
		else
			return $urandom_range(0, 130);
	endfunction

	// digest side
	initial begin
		int stall;
		out_ready = 1'b0;
		recv_burst = 0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(recv_burst);
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			tracker.check_digest(digest);
		end
	end

	initial begin
		int waited;
		tracker    = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		op         = op_absorb;
		data_byte  = 8'h00;
		items_sent = 0;
		send_burst = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty messages back to back, then short known messages
		send_item(op_finish, 8'hFF);
		send_item(op_finish, 8'h00);
		send_item(op_absorb, 8'h61);
		send_item(op_absorb, 8'h62);
		send_item(op_absorb, 8'h63);
		send_item(op_finish, 8'h5A);
		send_item(op_absorb, 8'h00);
		send_item(op_absorb, 8'hFF);
		send_item(op_absorb, 8'h80);
		send_item(op_finish, 8'hA5);
		send_item(op_absorb, 8'hFF);
		send_item(op_finish, 8'h00);

		while (items_sent < 1100)
			send_message(pick_length());

		@(negedge clk);
		in_valid = 1'b0;

		waited = 0;
		while (tracker.pending_digests.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		// a late finish can still be running two compressions
		repeat (300) @(posedge clk);
		while (tracker.pending_digests.size() != 0) begin
			void'(tracker.pending_digests.pop_front());
			tracker.report("expected digest never arrived");
		end

		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
